### sv/cssdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS declaration parser package
// Shared widths, codes, types and character helpers.
// ----------------------------------------------------------------------------
package cssdp_pkg;

    localparam int NAME_BUFFER_DEF = 20;
    localparam int VALUE_KEEP_DEF  = 510;
    localparam int PREFIX_LEN      = 12;
    localparam int PREFIX_IDX_W    = $clog2(PREFIX_LEN);
    localparam int PROP_W          = 5;
    localparam int VALUE_W         = 32;
    localparam int PIX_W           = 31;

    localparam logic [PROP_W-1:0] PROP_COLOR        = 5'd0;
    localparam logic [PROP_W-1:0] PROP_BACKGROUND   = 5'd1;
    localparam logic [PROP_W-1:0] PROP_FONT_SIZE    = 5'd2;
    localparam logic [PROP_W-1:0] PROP_MARGIN       = 5'd3;
    localparam logic [PROP_W-1:0] PROP_PADDING      = 5'd4;
    localparam logic [PROP_W-1:0] PROP_BORDER_WIDTH = 5'd5;
    localparam logic [PROP_W-1:0] PROP_WIDTH        = 5'd6;
    localparam logic [PROP_W-1:0] PROP_HEIGHT       = 5'd7;
    localparam logic [PROP_W-1:0] PROP_MAX_HEIGHT   = 5'd8;
    localparam logic [PROP_W-1:0] PROP_MIN_HEIGHT   = 5'd9;
    localparam logic [PROP_W-1:0] PROP_MAX_WIDTH    = 5'd10;
    localparam logic [PROP_W-1:0] PROP_MIN_WIDTH    = 5'd11;
    localparam logic [PROP_W-1:0] PROP_BORDER_COLOR = 5'd12;
    localparam logic [PROP_W-1:0] PROP_BORDER_STYLE = 5'd13;
    localparam logic [PROP_W-1:0] PROP_VISIBILITY   = 5'd14;
    localparam logic [PROP_W-1:0] PROP_OPACITY      = 5'd15;
    localparam logic [PROP_W-1:0] PROP_DISPLAY      = 5'd16;
    localparam logic [PROP_W-1:0] PROP_NONE         = 5'd17;

    localparam logic [PIX_W-1:0]   PIX_MAX         = 31'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] TRANSPARENT_RGB = 32'hFFFF_FFFF;

    typedef logic [7:0] char_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_NAME,
        PH_GAP,
        PH_VAL
    } phase_t;

    typedef struct packed {
        logic   closed;
        logic   decode_en;
        phase_t phase;
    } scan_ctrl_t;

    function automatic logic is_ws(input char_t c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic char_t to_lower(input char_t c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [3:0] hex_digit_val(input char_t c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - "a" + 8'd10);
        end
        return 4'd0;
    endfunction

endpackage

### sv/cssdp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS declaration parser scanner
// Holds the name and value buffers and advances them by one character.
// ----------------------------------------------------------------------------
module cssdp_scan
    import cssdp_pkg::*;
#(
    parameter int NAME_KEEP  = NAME_BUFFER_DEF - 1,
    parameter int VALUE_KEEP = VALUE_KEEP_DEF,
    parameter int NLW        = $clog2(NAME_KEEP + 1),
    parameter int VLW        = $clog2(VALUE_KEEP + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  char_t                ch,
    input  logic                 last,
    output char_t                name_mid [NAME_KEEP],
    output logic [NLW-1:0]       name_len_mid,
    output char_t                prefix_mid [PREFIX_LEN],
    output logic [VLW-1:0]       trim_mid,
    output logic [PIX_W-1:0]     acc_mid,
    output scan_ctrl_t           ctrl
);

    localparam int NIDX = $clog2(NAME_KEEP);

    phase_t           phase_reg, phase_next, phase_mid;
    char_t            name_reg [NAME_KEEP];
    char_t            prefix_reg [PREFIX_LEN];
    logic [NLW-1:0]   name_len_reg, name_len_next;
    logic [VLW-1:0]   kept_reg, kept_next, kept_mid;
    logic [VLW-1:0]   trim_reg, trim_next;
    logic [PIX_W-1:0] acc_reg, acc_next;
    logic             digits_reg, digits_next, digits_mid;
    logic             closed;
    logic             take;
    phase_t           ph;
    logic [PIX_W+3:0] prod;

    // Character processing. The clear that a ';' in the value causes is
    // left to the next-state block so the decoder sees the closed value.
    always_comb
    begin
        phase_mid    = phase_reg;
        name_mid     = name_reg;
        name_len_mid = name_len_reg;
        prefix_mid   = prefix_reg;
        kept_mid     = kept_reg;
        trim_mid     = trim_reg;
        acc_mid      = acc_reg;
        digits_mid   = digits_reg;
        closed       = 1'b0;
        take         = 1'b1;
        ph           = phase_reg;
        prod         = '0;
        if (ch != 8'd0)
        begin
            if (ph == PH_SKIP)
            begin
                if (is_ws(ch)) take = 1'b0;
                else ph = PH_NAME;
            end
            else if (ph == PH_GAP)
            begin
                if (is_ws(ch)) take = 1'b0;
                else ph = PH_VAL;
            end
            phase_mid = ph;
            if (take)
            begin
                if (ph == PH_NAME)
                begin
                    if (ch == ":")
                    begin
                        phase_mid  = PH_GAP;
                        kept_mid   = '0;
                        trim_mid   = '0;
                        acc_mid    = '0;
                        digits_mid = 1'b1;
                    end
                    else if (ch == ";")
                    begin
                        phase_mid    = PH_SKIP;
                        name_len_mid = '0;
                    end
                    else if (32'(name_len_reg) < NAME_KEEP)
                    begin
                        name_mid[name_len_reg[NIDX-1:0]] = to_lower(ch);
                        name_len_mid = name_len_reg + 1'b1;
                    end
                end
                else if (ch == ";")
                begin
                    closed    = 1'b1;
                    phase_mid = PH_SKIP;
                end
                else if (32'(kept_reg) < VALUE_KEEP)
                begin
                    if (32'(kept_reg) < PREFIX_LEN)
                    begin
                        prefix_mid[kept_reg[PREFIX_IDX_W-1:0]] = to_lower(ch);
                    end
                    kept_mid = kept_reg + 1'b1;
                    if (ch != 8'h20 && ch != 8'h09)
                    begin
                        trim_mid = kept_reg + 1'b1;
                    end
                    if (digits_reg && ch >= "0" && ch <= "9")
                    begin
                        prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                             + (PIX_W+4)'(ch - "0");
                        acc_mid = (prod > (PIX_W+4)'(PIX_MAX)) ? PIX_MAX
                                                              : prod[PIX_W-1:0];
                    end
                    else
                    begin
                        digits_mid = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        ctrl.closed    = closed;
        ctrl.decode_en = closed || (last && (phase_mid == PH_GAP || phase_mid == PH_VAL));
        ctrl.phase     = phase_reg;
    end

    always_comb
    begin
        phase_next    = phase_mid;
        name_len_next = name_len_mid;
        kept_next     = kept_mid;
        trim_next     = trim_mid;
        acc_next      = acc_mid;
        digits_next   = digits_mid;
        if (last || closed)
        begin
            phase_next    = PH_SKIP;
            name_len_next = '0;
            kept_next     = '0;
            trim_next     = '0;
            acc_next      = '0;
            digits_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            name_len_reg <= '0;
            kept_reg     <= '0;
            trim_reg     <= '0;
            acc_reg      <= '0;
            digits_reg   <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            name_len_reg <= name_len_next;
            kept_reg     <= kept_next;
            trim_reg     <= trim_next;
            acc_reg      <= acc_next;
            digits_reg   <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            name_reg   <= name_mid;
            prefix_reg <= prefix_mid;
        end
    end

endmodule

### sv/cssdp_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS declaration parser decoder
// Matches the property name and decodes the value of a finished declaration.
// ----------------------------------------------------------------------------
module cssdp_decode
    import cssdp_pkg::*;
#(
    parameter int NAME_KEEP  = NAME_BUFFER_DEF - 1,
    parameter int VALUE_KEEP = VALUE_KEEP_DEF,
    parameter int NLW        = $clog2(NAME_KEEP + 1),
    parameter int VLW        = $clog2(VALUE_KEEP + 1)
)
(
    input  char_t                name [NAME_KEEP],
    input  logic [NLW-1:0]       name_len,
    input  char_t                prefix [PREFIX_LEN],
    input  logic [VLW-1:0]       trim,
    input  logic [PIX_W-1:0]     acc,
    output logic [PROP_W-1:0]    prop,
    output logic [VALUE_W-1:0]   value
);

    logic [VALUE_W-1:0] color;
    logic [3:0]         n1, n2, n3, n4, n5, n6;

    // The word sits right-justified in w; its first character is highest.
    function automatic logic name_is(input logic [8*16-1:0] w, input int n);
        logic ok;
        ok = (32'(name_len) == n);
        for (int i = 0; i < 16; i++)
        begin
            if (i < n && name[i] != w[8*(n-1-i) +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic value_is(input logic [8*PREFIX_LEN-1:0] w, input int n);
        logic ok;
        ok = (32'(trim) == n);
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            if (i < n && prefix[i] != w[8*(n-1-i) +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb
    begin
        if      (name_is("color", 5))             prop = PROP_COLOR;
        else if (name_is("background-color", 16)) prop = PROP_BACKGROUND;
        else if (name_is("font-size", 9))         prop = PROP_FONT_SIZE;
        else if (name_is("margin", 6))            prop = PROP_MARGIN;
        else if (name_is("padding", 7))           prop = PROP_PADDING;
        else if (name_is("border-width", 12))     prop = PROP_BORDER_WIDTH;
        else if (name_is("width", 5))             prop = PROP_WIDTH;
        else if (name_is("height", 6))            prop = PROP_HEIGHT;
        else if (name_is("max-height", 10))       prop = PROP_MAX_HEIGHT;
        else if (name_is("min-height", 10))       prop = PROP_MIN_HEIGHT;
        else if (name_is("max-width", 9))         prop = PROP_MAX_WIDTH;
        else if (name_is("min-width", 9))         prop = PROP_MIN_WIDTH;
        else if (name_is("border-color", 12))     prop = PROP_BORDER_COLOR;
        else if (name_is("border-style", 12))     prop = PROP_BORDER_STYLE;
        else if (name_is("visibility", 10))       prop = PROP_VISIBILITY;
        else if (name_is("opacity", 7))           prop = PROP_OPACITY;
        else if (name_is("display", 7))           prop = PROP_DISPLAY;
        else                                      prop = PROP_NONE;
    end

    assign n1 = hex_digit_val(prefix[1]);
    assign n2 = hex_digit_val(prefix[2]);
    assign n3 = hex_digit_val(prefix[3]);
    assign n4 = hex_digit_val(prefix[4]);
    assign n5 = hex_digit_val(prefix[5]);
    assign n6 = hex_digit_val(prefix[6]);

    always_comb
    begin
        color = '0;
        if (trim != '0 && prefix[0] == "#")
        begin
            if (32'(trim) == 4)
                color = {8'h00, n1, n1, n2, n2, n3, n3};
            else if (32'(trim) == 7)
                color = {8'h00, n1, n2, n3, n4, n5, n6};
        end
        else if (value_is("transparent", 11)) color = TRANSPARENT_RGB;
        else if (value_is("red", 3))          color = 32'h00FF_0000;
        else if (value_is("green", 5))        color = 32'h0000_8000;
        else if (value_is("blue", 4))         color = 32'h0000_00FF;
        else if (value_is("black", 5))        color = 32'h0000_0000;
        else if (value_is("white", 5))        color = 32'h00FF_FFFF;
        else if (value_is("yellow", 6))       color = 32'h00FF_FF00;
        else if (value_is("cyan", 4))         color = 32'h0000_FFFF;
        else if (value_is("magenta", 7))      color = 32'h00FF_00FF;
        else if (value_is("orange", 6))       color = 32'h00FF_A500;
        else if (value_is("lime", 4))         color = 32'h0000_FF00;
        else if (value_is("gray", 4))         color = 32'h0080_8080;
        else if (value_is("grey", 4))         color = 32'h0080_8080;
    end

    always_comb
    begin
        value = '0;
        if (prop == PROP_COLOR || prop == PROP_BACKGROUND || prop == PROP_BORDER_COLOR)
            value = color;
        else if (prop >= PROP_FONT_SIZE && prop <= PROP_MIN_WIDTH)
            value = {1'b0, acc};
        else if (prop == PROP_BORDER_STYLE)
            value = {31'd0, value_is("solid", 5)};
        else if (prop == PROP_VISIBILITY)
            value = {31'd0, value_is("hidden", 6)};
        else if (prop == PROP_OPACITY)
            value = {31'd0, !(trim != '0 && prefix[0] == "0")};
        else if (prop == PROP_DISPLAY)
        begin
            if      (value_is("none", 4))          value = 32'd0;
            else if (value_is("block", 5))         value = 32'd1;
            else if (value_is("inline", 6))        value = 32'd2;
            else if (value_is("inline-block", 12)) value = 32'd3;
            else if (value_is("table", 5))         value = 32'd4;
            else if (value_is("table-row", 9))     value = 32'd5;
            else if (value_is("table-cell", 10))   value = 32'd6;
            else                                   value = 32'd2;
        end
    end

endmodule

### sv/css_declaration_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS declaration parser unit
// Decodes a CSS declaration list streamed one byte per request.
// ----------------------------------------------------------------------------
// Usage:
// The slave side takes one character per request in s_tdata, with s_tlast
// on the final character of the string; a zero byte is a filler. The master
// side returns one result per closed declaration of a known property, and
// always one result for the final request, which carries m_tlast.
// A request lands in the input register when it is accepted, is scanned and
// decoded from there, and its result is registered in the result register.
// The per-character scan and the name and value compares over the small
// buffers are combinational. Throughput is one request per cycle while the
// result register can take a result.
// While a result waits in the output register the input register still
// takes a request; the input side stalls only once both registers are full
// and m_tready is low. Reset clears all control state and both valid flags;
// the name and value buffers are not cleared, since only written entries
// are ever compared.
// ----------------------------------------------------------------------------
module css_declaration_parser_unit
    import cssdp_pkg::*;
#(
    parameter int NAME_BUFFER = NAME_BUFFER_DEF,
    parameter int VALUE_KEEP  = VALUE_KEEP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] property_res, [36:5] value, [39:37] zero
    output logic        m_tlast
);

    localparam int NAME_KEEP = NAME_BUFFER - 1;
    localparam int NLW       = $clog2(NAME_KEEP + 1);
    localparam int VLW       = $clog2(VALUE_KEEP + 1);

    logic               in_valid_reg;
    char_t              in_ch_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    logic [PROP_W-1:0]  out_prop_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_done_reg;
    logic               advance;
    logic               emit;
    logic [PROP_W-1:0]  prop_res;

    char_t              name_mid [NAME_KEEP];
    logic [NLW-1:0]     name_len_mid;
    char_t              prefix_mid [PREFIX_LEN];
    logic [VLW-1:0]     trim_mid;
    logic [PIX_W-1:0]   acc_mid;
    scan_ctrl_t         ctrl;
    logic [PROP_W-1:0]  dec_prop;
    logic [VALUE_W-1:0] dec_value;

    // The held request moves on whenever the result register can take a result.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cssdp_scan #(
        .NAME_KEEP  (NAME_KEEP),
        .VALUE_KEEP (VALUE_KEEP),
        .NLW        (NLW),
        .VLW        (VLW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .ch           (in_ch_reg),
        .last         (in_last_reg),
        .name_mid     (name_mid),
        .name_len_mid (name_len_mid),
        .prefix_mid   (prefix_mid),
        .trim_mid     (trim_mid),
        .acc_mid      (acc_mid),
        .ctrl         (ctrl)
    );

    cssdp_decode #(
        .NAME_KEEP  (NAME_KEEP),
        .VALUE_KEEP (VALUE_KEEP),
        .NLW        (NLW),
        .VLW        (VLW)
    ) u_decode (
        .name     (name_mid),
        .name_len (name_len_mid),
        .prefix   (prefix_mid),
        .trim     (trim_mid),
        .acc      (acc_mid),
        .prop     (dec_prop),
        .value    (dec_value)
    );

    // Without a declaration to report, the final request returns "none".
    assign prop_res = ctrl.decode_en ? dec_prop : PROP_NONE;
    assign emit     = in_last_reg || (ctrl.closed && dec_prop != PROP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && emit)
        begin
            out_prop_reg  <= prop_res;
            out_value_reg <= (prop_res == PROP_NONE) ? '0 : dec_value;
            out_done_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_prop_reg};
    assign m_tlast  = out_done_reg;

    // The final request of a string always yields a result marked last.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg && out_done_reg)
        else $error("final request gave no last result");

    // The scanner is back at the start of a declaration after a string ends.
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> ctrl.phase == PH_SKIP)
        else $error("scanner not reset after final request");

    // A result without the last mark always names a known property.
    a_known_prop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_done_reg |-> out_prop_reg < PROP_NONE)
        else $error("unknown property reported mid-string");

endmodule
